// File: rtl/riff_wave_header_parser_top_macros.svh
// Assertion macros for the RIFF/WAVE header parser.
`ifndef RIFF_WAVE_HEADER_PARSER_TOP_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define RWHP_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RWHP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RWHP_ASSERT(lbl, cond, msg)
`define RWHP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/rwhp_pkg.sv
// Shared types and constants of the RIFF/WAVE header parser.
package rwhp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNK_HDR,
        PH_FMT_BODY,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_TAG,
        ST_DATA_FIRST,
        ST_TRUNC,
        ST_SHORT_FMT
    } status_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [31:0] POS_SAT  = 32'hFFFF_FFFF;
    localparam logic [31:0] FMT_MIN  = 32'd16;

    typedef struct packed {
        status_t     status;
        logic [15:0] channels;
        logic [31:0] rate_hz;
        logic [15:0] sample_width;
        logic [31:0] body_offset;
        logic [31:0] body_size;
    } result_t;

    function automatic result_t make_result(
        input status_t     st,
        input logic [15:0] ch,
        input logic [31:0] rate,
        input logic [15:0] bits,
        input logic [31:0] offset,
        input logic [31:0] size
    );
        result_t r;
        r.status       = st;
        r.channels     = (st == ST_OK) ? ch     : 16'd0;
        r.rate_hz      = (st == ST_OK) ? rate   : 32'd0;
        r.sample_width = (st == ST_OK) ? bits   : 16'd0;
        r.body_offset  = (st == ST_OK) ? offset : 32'd0;
        r.body_size    = (st == ST_OK) ? size   : 32'd0;
        return r;
    endfunction

endpackage

// File: rtl/rwhp_core.sv
// Byte-wise chunk walker: tag checks, chunk skipping, fmt capture.
`include "riff_wave_header_parser_top_macros.svh"
module rwhp_core
    import rwhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  byte_in,
    input  logic        last,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [32:0] skip_reg, skip_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            fcnt_reg     <= '0;
            tag_reg      <= '0;
            len_reg      <= '0;
            skip_reg     <= '0;
            fmt_seen_reg <= 1'b0;
            ch_reg       <= '0;
            rate_reg     <= '0;
            bits_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            fcnt_reg     <= fcnt_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            skip_reg     <= skip_next;
            fmt_seen_reg <= fmt_seen_next;
            ch_reg       <= ch_next;
            rate_reg     <= rate_next;
            bits_reg     <= bits_next;
        end
    end

    always_comb
    begin
        logic [31:0] shifted_tag;
        logic [31:0] shifted_len;
        logic [32:0] skip_dec;

        phase_next    = phase_reg;
        pos_next      = (pos_reg == POS_SAT) ? pos_reg : pos_reg + 32'd1;
        fcnt_next     = fcnt_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        fmt_seen_next = fmt_seen_reg;
        ch_next       = ch_reg;
        rate_next     = rate_reg;
        bits_next     = bits_reg;
        res_valid     = 1'b0;
        res           = make_result(ST_OK, 16'd0, 32'd0, 16'd0, 32'd0, 32'd0);

        shifted_tag = {tag_reg[23:0], byte_in};
        shifted_len = {byte_in, len_reg[31:8]};
        skip_dec    = (skip_reg != 33'd0) ? skip_reg - 33'd1 : skip_reg;

        unique case (phase_reg)
            PH_HEADER:
            begin
                tag_next = shifted_tag;
                if ((fcnt_reg == 4'd3 && shifted_tag != TAG_RIFF) ||
                    (fcnt_reg == 4'd11 && shifted_tag != TAG_WAVE))
                begin
                    res_valid = 1'b1;
                    res = make_result(ST_BAD_TAG, 16'd0, 32'd0, 16'd0, 32'd0, 32'd0);
                end
                else if (fcnt_reg == 4'd11)
                begin
                    phase_next = PH_CHUNK_HDR;
                    fcnt_next  = '0;
                end
                else
                begin
                    fcnt_next = fcnt_reg + 4'd1;
                end
            end
            PH_CHUNK_HDR:
            begin
                if (fcnt_reg < 4'd4)
                    tag_next = shifted_tag;
                else
                    len_next = shifted_len;
                if (fcnt_reg >= 4'd7)
                begin
                    fcnt_next = '0;
                    if (tag_next == TAG_FMT)
                    begin
                        if (len_next < FMT_MIN)
                        begin
                            res_valid = 1'b1;
                            res = make_result(ST_SHORT_FMT, 16'd0, 32'd0, 16'd0,
                                              32'd0, 32'd0);
                        end
                        else
                        begin
                            phase_next = PH_FMT_BODY;
                        end
                    end
                    else if (tag_next == TAG_DATA)
                    begin
                        res_valid = 1'b1;
                        if (!fmt_seen_reg)
                            res = make_result(ST_DATA_FIRST, 16'd0, 32'd0, 16'd0,
                                              32'd0, 32'd0);
                        else if (pos_next == POS_SAT)
                            res = make_result(ST_TRUNC, 16'd0, 32'd0, 16'd0,
                                              32'd0, 32'd0);
                        else
                            res = make_result(ST_OK, ch_reg, rate_reg, bits_reg,
                                              pos_next, len_next);
                    end
                    else
                    begin
                        // unknown chunk: skip body plus pad byte
                        skip_next  = {1'b0, len_next} + {32'd0, len_next[0]};
                        phase_next = (skip_next == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
                else
                begin
                    fcnt_next = fcnt_reg + 4'd1;
                end
            end
            PH_FMT_BODY:
            begin
                if (fcnt_reg == 4'd2 || fcnt_reg == 4'd3)
                    ch_next = {byte_in, ch_reg[15:8]};
                else if (fcnt_reg >= 4'd4 && fcnt_reg <= 4'd7)
                    rate_next = {byte_in, rate_reg[31:8]};
                else if (fcnt_reg >= 4'd14)
                    bits_next = {byte_in, bits_reg[15:8]};
                if (fcnt_reg == 4'd15)
                begin
                    fmt_seen_next = 1'b1;
                    fcnt_next     = '0;
                    skip_next     = {1'b0, len_reg - FMT_MIN} + {32'd0, len_reg[0]};
                    phase_next    = (skip_next == 33'd0) ? PH_CHUNK_HDR : PH_SKIP;
                end
                else
                begin
                    fcnt_next = fcnt_reg + 4'd1;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 33'd0)
                    phase_next = PH_CHUNK_HDR;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (res_valid)
            phase_next = PH_DONE;

        if (last)
        begin
            if (!res_valid && phase_reg != PH_DONE)
            begin
                res_valid = 1'b1;
                res = make_result(ST_TRUNC, 16'd0, 32'd0, 16'd0, 32'd0, 32'd0);
            end
            // rearm for the next file
            phase_next    = PH_HEADER;
            pos_next      = '0;
            fcnt_next     = '0;
            tag_next      = '0;
            len_next      = '0;
            skip_next     = '0;
            fmt_seen_next = 1'b0;
            ch_next       = '0;
            rate_next     = '0;
            bits_next     = '0;
        end

        res_valid = res_valid && take;
    end

    `RWHP_ASSERT_NEXT(a_done_after_result, res_valid && !last, phase_reg == PH_DONE,
                      "result given but parser not parked")
    `RWHP_ASSERT(a_skip_nonzero, (phase_reg != PH_SKIP) || (skip_reg != 33'd0),
                 "skip phase with nothing to skip")
    `RWHP_ASSERT(a_fmt_len, (phase_reg != PH_FMT_BODY) || (len_reg >= FMT_MIN),
                 "fmt body entered with short length")

endmodule

// File: rtl/riff_wave_header_parser_top.sv
// RIFF/WAVE header parser top level: byte input, result output buffering.
//
// Takes a WAV file one byte per word on the input channel, "last" set on the
// final byte, and gives at most one result word per file: the channel count,
// sample rate and bits per sample from the fmt chunk, plus the file offset
// and size of the data chunk body (status 0), or a failure status with all
// other fields zero (1 bad RIFF/WAVE tag, 2 data chunk before fmt, 3 file
// ended or position overflowed before the data chunk, 4 fmt chunk shorter
// than 16 bytes). After a result, bytes are dropped until the last byte of
// the file, which rearms the parser; a file with no result gives status 3
// on its last byte. One byte is taken every clock; the result for a byte
// appears on the output the cycle after that byte is accepted when the
// output register is free, otherwise it waits in the skid register. An
// output register plus one skid register hold results, so input only stalls
// while two results are waiting to be taken. Reset needs no clearing pass.
`include "riff_wave_header_parser_top_macros.svh"
module riff_wave_header_parser_top
    import rwhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] channels,
    output logic [31:0] rate_hz,
    output logic [15:0] sample_width,
    output logic [31:0] body_offset,
    output logic [31:0] body_size
);

    logic    take;
    logic    res_valid;
    result_t res;

    logic    out_vld_reg, out_vld_next;
    logic    skid_vld_reg, skid_vld_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    // ready only drops when both result slots are full
    assign in_ready = !skid_vld_reg;
    assign take     = in_valid && in_ready;

    rwhp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_in   (byte_in),
        .last      (last),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_next      = out_reg;
        skid_next     = skid_reg;

        // drain: skid moves up when the output word is taken
        if (out_vld_reg && out_ready)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end

        // fill: new result goes to the first free slot
        if (res_valid)
        begin
            if (!out_vld_next)
            begin
                out_next     = res;
                out_vld_next = 1'b1;
            end
            else
            begin
                skid_next     = res;
                skid_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_vld_reg;
    assign status       = out_reg.status;
    assign channels     = out_reg.channels;
    assign rate_hz      = out_reg.rate_hz;
    assign sample_width = out_reg.sample_width;
    assign body_offset  = out_reg.body_offset;
    assign body_size    = out_reg.body_size;

    `RWHP_ASSERT(a_skid_implies_out, !skid_vld_reg || out_vld_reg,
                 "skid word held with empty output register")
    `RWHP_ASSERT(a_fail_zero_fields,
                 !out_vld_reg || out_reg.status == ST_OK ||
                 (out_reg.channels == 16'd0 && out_reg.rate_hz == 32'd0 &&
                  out_reg.sample_width == 16'd0 && out_reg.body_offset == 32'd0 &&
                  out_reg.body_size == 32'd0),
                 "failure result carries nonzero fields")
    `RWHP_ASSERT_NEXT(a_res_lands, res_valid, out_vld_reg,
                      "result lost on the way to the output register")

endmodule

// File: verif/riff_wave_header_checker.sv
// Checker for the RIFF/WAVE header parser: predicts each header report and compares it.
`timescale 1ns / 1ps
module riff_wave_header_checker
    import rwhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [15:0] channels,
    input  logic [31:0] rate_hz,
    input  logic [15:0] sample_width,
    input  logic [31:0] body_offset,
    input  logic [31:0] body_size,
    output int          mismatches,
    output int          reports_due
);

    // Parser state as seen by the predictor.
    phase_t      stage;
    logic [31:0] position;
    logic [3:0]  field_idx;
    logic [31:0] tag_shift;
    logic [31:0] chunk_len;
    logic [32:0] to_skip;
    logic        fmt_done;
    logic [15:0] held_ch;
    logic [31:0] held_rate;
    logic [15:0] held_bits;
    logic        reported;

    result_t header_reports[$];

    task automatic rearm_parser();
        stage     = PH_HEADER;
        position  = '0;
        field_idx = '0;
        tag_shift = '0;
        chunk_len = '0;
        to_skip   = '0;
        fmt_done  = 1'b0;
        held_ch   = '0;
        held_rate = '0;
        held_bits = '0;
        reported  = 1'b0;
    endtask

    // Failure reports carry only the status; all other fields read zero.
    function automatic result_t header_report(input status_t st, input logic [31:0] offset,
                                              input logic [31:0] size);
        result_t rep;
        rep = '0;
        rep.status = st;
        if (st == ST_OK)
        begin
            rep.channels     = held_ch;
            rep.rate_hz      = held_rate;
            rep.sample_width = held_bits;
            rep.body_offset  = offset;
            rep.body_size    = size;
        end
        return rep;
    endfunction

    task automatic parse_wav_byte(input logic [7:0] b, input logic fin);
        logic [3:0] k;
        bit         got;
        result_t    rep;
        k   = field_idx;
        got = 1'b0;
        rep = '0;
        if (position != POS_SAT)
            position++;
        case (stage)
            PH_HEADER:
            begin
                tag_shift = {tag_shift[23:0], b};
                if ((k == 4'd3 && tag_shift != TAG_RIFF) || (k == 4'd11 && tag_shift != TAG_WAVE))
                begin
                    rep = header_report(ST_BAD_TAG, '0, '0);
                    got = 1'b1;
                end
                else if (k == 4'd11)
                begin
                    stage     = PH_CHUNK_HDR;
                    field_idx = '0;
                end
                else
                    field_idx = k + 4'd1;
            end
            PH_CHUNK_HDR:
            begin
                if (k < 4'd4)
                    tag_shift = {tag_shift[23:0], b};
                else
                    chunk_len = {b, chunk_len[31:8]};
                if (k >= 4'd7)
                begin
                    field_idx = '0;
                    if (tag_shift == TAG_FMT)
                    begin
                        if (chunk_len < FMT_MIN)
                        begin
                            rep = header_report(ST_SHORT_FMT, '0, '0);
                            got = 1'b1;
                        end
                        else
                            stage = PH_FMT_BODY;
                    end
                    else if (tag_shift == TAG_DATA)
                    begin
                        got = 1'b1;
                        if (!fmt_done)
                            rep = header_report(ST_DATA_FIRST, '0, '0);
                        else if (position == POS_SAT)
                            rep = header_report(ST_TRUNC, '0, '0);
                        else
                            rep = header_report(ST_OK, position, chunk_len);
                    end
                    else
                    begin
                        // body plus pad byte on odd sizes
                        to_skip = {1'b0, chunk_len} + {32'd0, chunk_len[0]};
                        stage   = (to_skip == '0) ? PH_CHUNK_HDR : PH_SKIP;
                    end
                end
                else
                    field_idx = k + 4'd1;
            end
            PH_FMT_BODY:
            begin
                if (k == 4'd2 || k == 4'd3)
                    held_ch = {b, held_ch[15:8]};
                else if (k >= 4'd4 && k <= 4'd7)
                    held_rate = {b, held_rate[31:8]};
                else if (k >= 4'd14)
                    held_bits = {b, held_bits[15:8]};
                if (k == 4'd15)
                begin
                    fmt_done  = 1'b1;
                    field_idx = '0;
                    to_skip   = {1'b0, chunk_len - FMT_MIN} + {32'd0, chunk_len[0]};
                    stage     = (to_skip == '0) ? PH_CHUNK_HDR : PH_SKIP;
                end
                else
                    field_idx = k + 4'd1;
            end
            PH_SKIP:
            begin
                if (to_skip != '0)
                    to_skip--;
                if (to_skip == '0)
                    stage = PH_CHUNK_HDR;
            end
            default:
            begin
            end
        endcase
        if (got)
        begin
            reported = 1'b1;
            stage    = PH_DONE;
        end
        if (fin)
        begin
            if (!got && !reported)
            begin
                rep = header_report(ST_TRUNC, '0, '0);
                got = 1'b1;
            end
            rearm_parser();
        end
        if (got)
            header_reports.push_back(rep);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            rearm_parser();
            header_reports.delete();
            mismatches  = 0;
            reports_due = 0;
        end
        else
        begin
            // A report leaves through the output register only after its byte is taken, so compare first.
            if (out_valid && out_ready)
            begin
                if (header_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected report, expected none, actual status %0d",
                             $time, status);
                end
                else
                begin
                    want = header_reports.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("channels", 32'(want.channels), 32'(channels));
                    check_field("rate_hz", want.rate_hz, rate_hz);
                    check_field("sample_width", 32'(want.sample_width),
                                32'(sample_width));
                    check_field("body_offset", want.body_offset, body_offset);
                    check_field("body_size", want.body_size, body_size);
                end
            end
            if (in_valid && in_ready)
                parse_wav_byte(byte_in, last);
            reports_due = header_reports.size();
        end
    end

endmodule

// File: verif/testbench.sv
// Top of the RIFF/WAVE header parser testbench: clock, reset, WAV byte streams, verdict.
`timescale 1ns / 1ps
module testbench
    import rwhp_pkg::*;
();

    localparam int          STALL_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int          HOLD_CYCLES = 80;    // long receiver hold-off
    localparam logic [31:0] TAG_LIST    = 32'h4C49_5354;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] sample_width;
    logic [31:0] body_offset;
    logic [31:0] body_size;

    int mismatches;
    int reports_due;

    // Sender bookkeeping
    logic [7:0] wav_bytes[$];   // file being built, sent in order from offset zero
    int         burst_left = 0;
    int         bytes_sent = 0;
    int         files_sent = 0;
    int         idle_cycles = 0;

    // Long hold-off request: raised by the sender side, taken by the receiver side.
    bit hold_armed = 1'b0;
    bit hold_taken = 1'b0;

    riff_wave_header_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .channels     (channels),
        .rate_hz      (rate_hz),
        .sample_width (sample_width),
        .body_offset  (body_offset),
        .body_size    (body_size)
    );

    riff_wave_header_checker wav_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_in      (byte_in),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .channels     (channels),
        .rate_hz      (rate_hz),
        .sample_width (sample_width),
        .body_offset  (body_offset),
        .body_size    (body_size),
        .mismatches   (mismatches),
        .reports_due  (reports_due)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // File builders. Tags go out in text order (big-endian value), sizes
    // and fmt fields little-endian, as in a real WAV file.
    // ------------------------------------------------------------------
    task automatic put_random(input int n);
        for (int i = 0; i < n; i++)
            wav_bytes.push_back(8'($urandom));
    endtask

    task automatic put_be32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            wav_bytes.push_back(v[31 - 8 * i -: 8]);
    endtask

    task automatic put_le32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            wav_bytes.push_back(v[8 * i +: 8]);
    endtask

    task automatic put_chunk_hdr(input logic [31:0] tag, input logic [31:0] len);
        put_be32(tag);
        put_le32(len);
    endtask

    // "RIFF", file size (never checked), "WAVE"
    task automatic put_riff_head(input logic [31:0] riff_size);
        put_be32(TAG_RIFF);
        put_le32(riff_size);
        put_be32(TAG_WAVE);
    endtask

    // fmt chunk of len >= 16: format code and the middle fields are random,
    // the rest of the body beyond 16 bytes is random, plus pad on odd len.
    task automatic put_fmt(input logic [31:0] len, input logic [15:0] ch,
                           input logic [31:0] rate, input logic [15:0] bits);
        put_chunk_hdr(TAG_FMT, len);
        put_random(2);
        wav_bytes.push_back(ch[7:0]);
        wav_bytes.push_back(ch[15:8]);
        put_le32(rate);
        put_random(6);
        wav_bytes.push_back(bits[7:0]);
        wav_bytes.push_back(bits[15:8]);
        put_random(int'(len - 32'd16 + len[0]));
    endtask

    // Any tag the parser must skip over.
    function automatic logic [31:0] other_tag();
        logic [31:0] t;
        t = $urandom;
        if (t == TAG_FMT || t == TAG_DATA)
            t = t ^ 32'h1;
        return t;
    endfunction

    task automatic put_extra();
        int len;
        len = $urandom_range(0, 9);
        put_chunk_hdr(other_tag(), len);
        put_random(len + len % 2);
    endtask

    // Well-formed file up to and including the data chunk header.
    task automatic put_good_wav();
        logic [31:0] size;
        put_riff_head($urandom);
        repeat ($urandom_range(0, 2)) put_extra();
        put_fmt(16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0),
                16'($urandom), $urandom, 16'($urandom));
        if ($urandom_range(0, 9) == 0)
            put_fmt(16 + $urandom_range(0, 3), 16'($urandom), $urandom, 16'($urandom));
        repeat ($urandom_range(0, 1)) put_extra();
        case ($urandom_range(0, 3))
            0:       size = 32'h0;
            1:       size = 32'hFFFF_FFFF;
            2:       size = $urandom;
            default: size = $urandom_range(1, 4096);
        endcase
        put_chunk_hdr(TAG_DATA, size);
    endtask

    // Half are well-formed files with random content; the rest are broken ones.
    task automatic put_random_wav();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            put_good_wav();
            put_random($urandom_range(0, 5));  // start of data body, dropped by the block
        end
        else if (pick < 65)
        begin
            // file ends before any data header
            if ($urandom_range(0, 2) == 0)
            begin
                put_riff_head($urandom);
                put_chunk_hdr(other_tag(), $urandom);
                put_random($urandom_range(0, 8));
            end
            else
            begin
                put_good_wav();
                n = $urandom_range(1, wav_bytes.size() - 1);
                while (wav_bytes.size() > n)
                    void'(wav_bytes.pop_back());
            end
        end
        else if (pick < 75)
        begin
            // corrupt one byte of the RIFF tag or of the WAVE tag
            put_riff_head($urandom);
            n = $urandom_range(0, 7);
            n = (n < 4) ? n : n + 4;
            wav_bytes[n] = wav_bytes[n] ^ 8'($urandom_range(1, 255));
            put_random($urandom_range(0, 4));
        end
        else if (pick < 83)
        begin
            put_riff_head($urandom);
            repeat ($urandom_range(0, 1)) put_extra();
            put_chunk_hdr(TAG_FMT, $urandom_range(0, 15));
            put_random($urandom_range(0, 4));
        end
        else if (pick < 91)
        begin
            put_riff_head($urandom);
            repeat ($urandom_range(0, 1)) put_extra();
            put_chunk_hdr(TAG_DATA, $urandom);
            put_random($urandom_range(0, 3));
        end
        else
            put_random($urandom_range(1, 12));
    endtask

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge, returns at a falling edge. Words go
    // out in bursts of random length with random gaps; some gaps are zero,
    // so bursts chain into longer stretches with no idling.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        last     <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send the built file with last on its final byte.
    task automatic send_wav();
        for (int i = 0; i < wav_bytes.size(); i++)
            send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
        wav_bytes.delete();
        files_sent++;
    endtask

    // Sender pause: idle until every predicted report has come out.
    task automatic wait_reports_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (reports_due != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, switching mode every so often, and
    // one long hold-off when the sender asks for it.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    // Watchdog: cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Last byte with nothing parsed: truncation report (status 3) with all other fields zero.
        put_random(0);
        wav_bytes.push_back(8'hFF);
        send_wav();

        // Bad RIFF tag on its fourth byte, which is also the last byte.
        put_be32(TAG_RIFF ^ 32'h1);
        send_wav();

        // Bad WAVE tag, then bytes that the block drops until the last one.
        put_riff_head(32'hFFFF_FFFF);
        wav_bytes[10] = wav_bytes[10] ^ 8'h01;
        put_random(3);
        send_wav();

        // fmt chunk shorter than 16 bytes.
        put_riff_head(32'h0);
        put_chunk_hdr(TAG_FMT, 32'd15);
        put_random(2);
        send_wav();

        // data chunk before any fmt body, report on the last byte.
        put_riff_head(32'h0);
        put_chunk_hdr(TAG_DATA, 32'h0);
        send_wav();

        // All-ones fields everywhere, report on the last byte.
        put_riff_head(32'hFFFF_FFFF);
        put_fmt(32'd16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_chunk_hdr(TAG_DATA, 32'hFFFF_FFFF);
        send_wav();

        // Odd chunk with pad, empty chunk, odd fmt with pad, second fmt
        // overwriting with zeros, data size zero, then body bytes.
        put_riff_head(32'h0);
        put_chunk_hdr(TAG_LIST, 32'd1);
        put_random(2);
        put_chunk_hdr(TAG_LIST, 32'd0);
        put_fmt(32'd17, 16'd1, 32'd44100, 16'd16);
        put_fmt(32'd16, 16'h0, 32'h0, 16'h0);
        put_chunk_hdr(TAG_DATA, 32'h0);
        put_random(4);
        send_wav();

        // Huge chunk being skipped when the file ends.
        put_riff_head(32'h0);
        put_chunk_hdr(TAG_LIST, 32'hFFFF_FFFF);
        put_random(6);
        send_wav();

        // File ends inside the fmt body.
        put_riff_head(32'h0);
        put_fmt(32'd16, 16'd2, 32'd48000, 16'd24);
        repeat (6) void'(wav_bytes.pop_back());
        send_wav();

        wait_reports_drained();

        // Random files up to about 1050 bytes; periodic drains let the
        // pipeline empty mid-run.
        while (bytes_sent < 1050)
        begin
            put_random_wav();
            send_wav();
            if (!hold_armed && files_sent >= 15)
            begin
                // Back-to-back one-byte files while the receiver holds off:
                // each gives a report, so the output side fills and input stalls.
                hold_armed = 1'b1;
                repeat (10)
                begin
                    put_random(1);
                    send_wav();
                end
                wait_reports_drained();
            end
            if (files_sent % 20 == 0)
                wait_reports_drained();
        end

        wait_reports_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
